[rtl/core/dlrd_pkg.sv]
// Shared types and constants for the dual line receiver demux.
package dlrd_pkg;

  // Default line buffer size in bytes
  localparam int unsigned LINE_BUF_SIZE_DEF = 1024;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_RX_BYTE       = 3'd0,
    OP_TAKE_PUB      = 3'd1,
    OP_RELEASE_PUB   = 3'd2,
    OP_REQ_ISSUED    = 3'd3,
    OP_RESP_CONSUMED = 3'd4
  } op_t;

  // Line completion codes
  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_PUB  = 2'd1;
  localparam logic [1:0] DONE_RESP = 2'd2;

  // Store targets
  localparam logic TGT_PUB  = 1'b0;
  localparam logic TGT_RESP = 1'b1;

  // Framing characters
  localparam logic [7:0] CH_PUB  = 8'h23;  // '#'
  localparam logic [7:0] CH_RESP = 8'h3A;  // ':'
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // Flag fields of one result
  typedef struct packed {
    logic       store_valid;
    logic       store_target;
    logic [1:0] line_done;
    logic       take_granted;
    logic       pub_ready;
    logic       resp_ready;
  } flags_t;

endpackage

[rtl/core/dlrd_in_stage.sv]
// Input register stage: holds one accepted request until it is processed.
module dlrd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [2:0] item_op,
  output logic [7:0] item_byte
);

  logic       valid_r, valid_nxt;
  logic [2:0] op_r;
  logic [7:0] byte_r;
  logic       accept;

  // Room when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      byte_r <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_op    = op_r;
  assign item_byte  = byte_r;

endmodule

[rtl/core/dlrd_line_ctrl.sv]
// Line capture state and per-request decision logic.
module dlrd_line_ctrl #(
  parameter int unsigned LINE_BUF_SIZE = dlrd_pkg::LINE_BUF_SIZE_DEF,
  localparam int unsigned AW = $clog2(LINE_BUF_SIZE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [2:0]        op,
  input  logic [7:0]        rx_byte,
  output dlrd_pkg::flags_t  flags,
  output logic [AW-1:0]     store_addr,
  output logic [7:0]        store_data,
  output logic [AW-1:0]     line_length
);

  localparam logic [AW-1:0] CAP = AW'(LINE_BUF_SIZE - 1);

  // Position saturates at CAP: beyond it only "not zero, not below CAP" matters
  logic [AW-1:0] pos_r, pos_nxt;
  logic cap_pub_r, cap_pub_nxt;
  logic cap_resp_r, cap_resp_nxt;
  logic held_r, held_nxt;
  logic await_r, await_nxt;
  logic pub_rcv_r, pub_rcv_nxt;
  logic resp_rcv_r, resp_rcv_nxt;
  logic cr_r, cr_nxt;

  always_comb begin
    logic          at_start;
    logic [AW-1:0] len;
    at_start     = (pos_r == '0);
    len          = (pos_r != '0 && cr_r) ? pos_r - 1'b1 : pos_r;
    pos_nxt      = pos_r;
    cap_pub_nxt  = cap_pub_r;
    cap_resp_nxt = cap_resp_r;
    held_nxt     = held_r;
    await_nxt    = await_r;
    pub_rcv_nxt  = pub_rcv_r;
    resp_rcv_nxt = resp_rcv_r;
    cr_nxt       = cr_r;
    flags        = '0;
    store_addr   = '0;
    store_data   = '0;
    line_length  = '0;

    unique case (dlrd_pkg::op_t'(op))
      dlrd_pkg::OP_RX_BYTE: begin
        // Line start markers
        if (at_start && rx_byte == dlrd_pkg::CH_PUB) begin
          if (!held_r && !cap_pub_r) begin
            pub_rcv_nxt = 1'b0;
            cap_pub_nxt = 1'b1;
          end
        end else if (at_start && rx_byte == dlrd_pkg::CH_RESP) begin
          if (await_r) begin
            await_nxt    = 1'b0;
            cap_resp_nxt = 1'b1;
          end
        end
        // End of line, store, or just count
        if (rx_byte == dlrd_pkg::CH_LF) begin
          if (cap_pub_nxt) begin
            flags.line_done = dlrd_pkg::DONE_PUB;
            line_length     = len;
            pub_rcv_nxt     = 1'b1;
            cap_pub_nxt     = 1'b0;
          end else if (cap_resp_nxt) begin
            flags.line_done = dlrd_pkg::DONE_RESP;
            line_length     = len;
            resp_rcv_nxt    = 1'b1;
            cap_resp_nxt    = 1'b0;
          end
          pos_nxt = '0;
          cr_nxt  = 1'b0;
        end else if ((cap_pub_nxt || cap_resp_nxt) && pos_r < CAP) begin
          flags.store_valid  = 1'b1;
          flags.store_target = cap_pub_nxt ? dlrd_pkg::TGT_PUB : dlrd_pkg::TGT_RESP;
          store_addr         = pos_r;
          store_data         = rx_byte;
          cr_nxt             = (rx_byte == dlrd_pkg::CH_CR);
          pos_nxt            = pos_r + 1'b1;
        end else if (pos_r < CAP) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      dlrd_pkg::OP_TAKE_PUB: begin
        if (!held_r && !cap_pub_r && pub_rcv_r) begin
          held_nxt           = 1'b1;
          flags.take_granted = 1'b1;
        end
      end
      dlrd_pkg::OP_RELEASE_PUB: begin
        pub_rcv_nxt = 1'b0;
        held_nxt    = 1'b0;
      end
      dlrd_pkg::OP_REQ_ISSUED: begin
        await_nxt = 1'b1;
      end
      dlrd_pkg::OP_RESP_CONSUMED: begin
        resp_rcv_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    flags.pub_ready  = pub_rcv_nxt;
    flags.resp_ready = resp_rcv_nxt;
  end

  // State commits only when the request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      cap_pub_r  <= 1'b0;
      cap_resp_r <= 1'b0;
      held_r     <= 1'b0;
      await_r    <= 1'b0;
      pub_rcv_r  <= 1'b0;
      resp_rcv_r <= 1'b0;
      cr_r       <= 1'b0;
    end else if (advance) begin
      pos_r      <= pos_nxt;
      cap_pub_r  <= cap_pub_nxt;
      cap_resp_r <= cap_resp_nxt;
      held_r     <= held_nxt;
      await_r    <= await_nxt;
      pub_rcv_r  <= pub_rcv_nxt;
      resp_rcv_r <= resp_rcv_nxt;
      cr_r       <= cr_nxt;
    end
  end

endmodule

[rtl/core/dlrd_out_stage.sv]
// Result register: holds one result until the consumer takes it.
module dlrd_out_stage #(
  parameter int unsigned LINE_BUF_SIZE = dlrd_pkg::LINE_BUF_SIZE_DEF,
  localparam int unsigned AW = $clog2(LINE_BUF_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             advance,
  input  dlrd_pkg::flags_t flags,
  input  logic [AW-1:0]    store_addr,
  input  logic [7:0]       store_data,
  input  logic [AW-1:0]    line_length,
  input  logic             out_ready,
  output logic             out_valid,
  output dlrd_pkg::flags_t out_flags,
  output logic [AW-1:0]    out_addr,
  output logic [7:0]       out_data,
  output logic [AW-1:0]    out_length
);

  logic             valid_r, valid_nxt;
  dlrd_pkg::flags_t flags_r;
  logic [AW-1:0]    addr_r;
  logic [7:0]       data_r;
  logic [AW-1:0]    len_r;

  // Load when empty or when the held result is taken this cycle
  assign advance = item_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r <= flags;
      addr_r  <= store_addr;
      data_r  <= store_data;
      len_r   <= line_length;
    end
  end

  assign out_valid  = valid_r;
  assign out_flags  = flags_r;
  assign out_addr   = addr_r;
  assign out_data   = data_r;
  assign out_length = len_r;

endmodule

[rtl/core/dual_line_receiver_demux.sv]
// Top level of the dual line receiver demux.
// Splits received serial bytes into a publication line ('#' first) and a
// response line (':' first, only while a request awaits one), and tracks host
// ownership of the publication buffer. Every request yields exactly one
// result: a buffer write (target, address, byte), a line completion with its
// length (trailing CR removed, clamped to LINE_BUF_SIZE-1), the take grant,
// and both ready flags. One request is accepted per cycle while the input
// register has room; each passes the input register and then the result
// register, which holds it while out_ready is low. A new request can enter
// the input register as the held one moves on to the result register.
module dual_line_receiver_demux #(
  parameter int unsigned LINE_BUF_SIZE = dlrd_pkg::LINE_BUF_SIZE_DEF,
  localparam int unsigned AW = $clog2(LINE_BUF_SIZE)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_op,
  input  logic [7:0]    in_rx_byte,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_store_valid,
  output logic          out_store_target,
  output logic [AW-1:0] out_store_addr,
  output logic [7:0]    out_store_data,
  output logic [1:0]    out_line_done,
  output logic [AW-1:0] out_line_length,
  output logic          out_take_granted,
  output logic          out_pub_ready,
  output logic          out_resp_ready
);

  logic             advance;
  logic             item_valid;
  logic [2:0]       item_op;
  logic [7:0]       item_byte;
  dlrd_pkg::flags_t flags;
  logic [AW-1:0]    store_addr;
  logic [7:0]       store_data;
  logic [AW-1:0]    line_length;
  dlrd_pkg::flags_t out_flags;

  dlrd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_op    (item_op),
    .item_byte  (item_byte)
  );

  dlrd_line_ctrl #(.LINE_BUF_SIZE(LINE_BUF_SIZE)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .op          (item_op),
    .rx_byte     (item_byte),
    .flags       (flags),
    .store_addr  (store_addr),
    .store_data  (store_data),
    .line_length (line_length)
  );

  dlrd_out_stage #(.LINE_BUF_SIZE(LINE_BUF_SIZE)) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .advance     (advance),
    .flags       (flags),
    .store_addr  (store_addr),
    .store_data  (store_data),
    .line_length (line_length),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_flags   (out_flags),
    .out_addr    (out_store_addr),
    .out_data    (out_store_data),
    .out_length  (out_line_length)
  );

  assign out_store_valid  = out_flags.store_valid;
  assign out_store_target = out_flags.store_target;
  assign out_line_done    = out_flags.line_done;
  assign out_take_granted = out_flags.take_granted;
  assign out_pub_ready    = out_flags.pub_ready;
  assign out_resp_ready   = out_flags.resp_ready;

`ifndef ASSERT_OFF
  // A result never both stores a byte and completes a line
  a_store_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_store_valid && out_line_done != dlrd_pkg::DONE_NONE))
    else $error("store and line completion in one result");

  // Completing a publication line leaves it ready
  a_pub_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done == dlrd_pkg::DONE_PUB |-> out_pub_ready)
    else $error("publication completed but not ready");

  // Completing a response line leaves it ready
  a_resp_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done == dlrd_pkg::DONE_RESP |-> out_resp_ready)
    else $error("response completed but not ready");

  // A granted take only happens on a waiting publication
  a_grant_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_take_granted |-> out_pub_ready && !out_store_valid)
    else $error("take granted without a waiting publication");
`endif

endmodule
